// File: hw/rtl/tthp_pkg.sv
// ----------------------------------------------------------------------------
// TTA header parser package
// Shared constants and codes for the header and seek table parser.
// ----------------------------------------------------------------------------
package tthp_pkg;

  localparam int unsigned MaxFramesDef = 4095;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] HdrLen = 32'd22;
  localparam logic [31:0] FrameDiv = 32'd245;
  localparam logic [31:0] MinFrame = 32'd4;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_SEEK = 2'd1,
    MODE_NEXT = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    EV_HDR_OK    = 4'd0,
    EV_HDR_CRC   = 4'd1,
    EV_HDR_BAD   = 4'd2,
    EV_TBL_OK    = 4'd3,
    EV_TBL_CRC   = 4'd4,
    EV_FRM_SMALL = 4'd5,
    EV_SEEK_DONE = 4'd6,
    EV_SEEK_OOR  = 4'd7,
    EV_FRM_READY = 4'd8,
    EV_END       = 4'd9,
    EV_NOT_READY = 4'd10
  } event_e;

endpackage

// File: hw/rtl/tta_header_seektable_parser.sv
// ----------------------------------------------------------------------------
// TTA header and seek table parser
// Parses the file header and seek table byte by byte with bit-serial CRC-32
// checks, then answers seek and next-frame requests from a frame end store.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         start, mode_i, data_byte_i, sample_position_i (busy out)
// result    out        result_valid_o, event_code_o and the header fields
//
// After a transaction the block is busy while a header or table byte that enters
// the CRC is shifted in bit by bit, and not busy on other bytes or ignored requests.
// The last header byte with a good CRC keeps it busy for two 32-step serial
// divisions, or for only the first when the frame length comes out zero.
// A seek takes a 32-step division plus a 12-step shift-add multiply.
// A next-frame request makes two reads of the frame end store.
// Results are strobed for one cycle and cannot be stalled; after reset the
// block is ready at once and the store needs no clearing.
module tta_header_seektable_parser #(
  parameter int unsigned MAX_FRAMES = tthp_pkg::MaxFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic [31:0]       sample_position_i,
  output logic              result_valid_o,
  output tthp_pkg::event_e  event_code_o,
  output logic [31:0]       byte_offset_o,
  output logic [11:0]       frame_index_o,
  output logic [31:0]       frame_bytes_o,
  output logic [31:0]       start_sample_o,
  output logic [15:0]       channel_count_o,
  output logic [15:0]       sample_bits_o,
  output logic [31:0]       sample_rate_o,
  output logic [31:0]       total_samples_o,
  output logic [31:0]       frame_samples_o,
  output logic [11:0]       total_frames_o
);
  import tthp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned Depth = MAX_FRAMES + 1;

  typedef enum logic [1:0] {
    PH_HEADER, PH_TABLE, PH_READY, PH_STOP
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_DFL, S_DFC, S_DSK, S_MUL, S_NX0, S_NX1, S_NX2
  } state_e;

  state_e state_q;
  phase_e phase_q;
  logic [14:0] pos_q;
  logic [31:0] crc_q, wa_q;
  logic [15:0] chan_q, bits_q;
  logic [31:0] rate_q, samp_q, flen_q, sum_q;
  logic [AW-1:0] cnt_frm_q, next_q, raddr_q, mplier_q;
  logic small_q;
  logic [2:0] bcnt_q;
  logic [4:0] step_q;
  logic [31:0] num_q, den_q, rem_q, mcand_q, acc_q, fstart_q, rdata_q;
  logic valid_q;
  event_e ev_q;
  logic [31:0] off_q, fbytes_q, ssamp_q;
  logic [AW-1:0] idx_q;

  logic [31:0] mem_q [Depth];

  logic accept;
  logic [31:0] wa_new, dlen, rdiff;
  logic [32:0] rem_t, frames;
  logic ge;
  logic [31:0] q_fin, r_fin, acc_fin;
  logic [AW-1:0] kidx, idx_min;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign wa_new = {data_byte_i, wa_q[31:8]};
  assign dlen = 32'({cnt_frm_q, 2'b00});
  assign kidx = pos_q[AW+1:2];
  assign rem_t = {rem_q, num_q[31]};
  assign ge = (rem_t >= {1'b0, den_q});
  assign rdiff = 32'(rem_t - {1'b0, den_q});
  assign r_fin = ge ? rdiff : rem_t[31:0];
  assign q_fin = {num_q[30:0], ge};
  assign frames = {1'b0, q_fin} + {32'd0, (r_fin != 32'd0)};
  assign idx_min = (q_fin > 32'(cnt_frm_q)) ? cnt_frm_q : q_fin[AW-1:0];
  assign acc_fin = acc_q + (mplier_q[0] ? mcand_q : 32'd0);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = sum_q + wa_new;
    if (accept && mode_i == MODE_BYTE && phase_q == PH_TABLE &&
        32'(pos_q) < dlen && pos_q[1:0] == 2'b11) begin
      mem_we = 1'b1;
      mem_wa = AW'(kidx + 1'b1);
    end else if (state_q == S_DFC && step_q == 5'd31) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = HdrLen + {frames[29:0], 2'b00} + MinFrame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_HEADER;
      pos_q <= '0;
      crc_q <= '1;
      wa_q <= '0;
      chan_q <= '0;
      bits_q <= '0;
      rate_q <= '0;
      samp_q <= '0;
      flen_q <= '0;
      cnt_frm_q <= '0;
      small_q <= 1'b0;
      next_q <= '0;
      valid_q <= 1'b0;
      ev_q <= EV_HDR_OK;
      bcnt_q <= '0;
      step_q <= '0;
      sum_q <= '0;
      raddr_q <= '0;
      mplier_q <= '0;
      num_q <= '0;
      den_q <= '0;
      rem_q <= '0;
      mcand_q <= '0;
      acc_q <= '0;
      fstart_q <= '0;
      off_q <= '0;
      fbytes_q <= '0;
      ssamp_q <= '0;
      idx_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            off_q <= '0;
            idx_q <= '0;
            fbytes_q <= '0;
            ssamp_q <= '0;
            unique case (mode_i)
              MODE_BYTE: begin
                if (phase_q == PH_HEADER) begin
                  wa_q <= wa_new;
                  pos_q <= 15'(pos_q + 1'b1);
                  if (pos_q == 15'd7) chan_q <= wa_new[31:16];
                  if (pos_q == 15'd9) bits_q <= wa_new[31:16];
                  if (pos_q == 15'd13) rate_q <= wa_new;
                  if (pos_q == 15'd17) samp_q <= wa_new;
                  if (pos_q < 15'd18) begin
                    crc_q <= crc_q ^ {24'd0, data_byte_i};
                    bcnt_q <= '0;
                    state_q <= S_CRC;
                  end else if (pos_q == 15'd21) begin
                    phase_q <= PH_STOP;
                    if (~crc_q != wa_new) begin
                      valid_q <= 1'b1;
                      ev_q <= EV_HDR_CRC;
                    end else begin
                      num_q <= {rate_q[23:0], 8'd0};
                      den_q <= FrameDiv;
                      rem_q <= '0;
                      step_q <= '0;
                      state_q <= S_DFL;
                    end
                  end
                end else if (phase_q == PH_TABLE) begin
                  wa_q <= wa_new;
                  pos_q <= 15'(pos_q + 1'b1);
                  if (32'(pos_q) < dlen) begin
                    crc_q <= crc_q ^ {24'd0, data_byte_i};
                    bcnt_q <= '0;
                    state_q <= S_CRC;
                    if (pos_q[1:0] == 2'b11) begin
                      sum_q <= mem_wd;
                      if (wa_new < MinFrame) small_q <= 1'b1;
                    end
                  end else if (32'(pos_q) == dlen + 32'd3) begin
                    valid_q <= 1'b1;
                    phase_q <= PH_STOP;
                    if (~crc_q != wa_new) begin
                      ev_q <= EV_TBL_CRC;
                    end else if (small_q) begin
                      ev_q <= EV_FRM_SMALL;
                    end else begin
                      ev_q <= EV_TBL_OK;
                      phase_q <= PH_READY;
                      next_q <= '0;
                    end
                  end
                end
              end
              MODE_SEEK, MODE_NEXT: begin
                if (phase_q != PH_READY || flen_q == 32'd0) begin
                  valid_q <= 1'b1;
                  ev_q <= EV_NOT_READY;
                end else if (mode_i == MODE_SEEK) begin
                  if (sample_position_i > samp_q) begin
                    valid_q <= 1'b1;
                    ev_q <= EV_SEEK_OOR;
                  end else begin
                    num_q <= sample_position_i;
                    den_q <= flen_q;
                    rem_q <= '0;
                    step_q <= '0;
                    state_q <= S_DSK;
                  end
                end else if (next_q >= cnt_frm_q) begin
                  valid_q <= 1'b1;
                  ev_q <= EV_END;
                end else begin
                  raddr_q <= next_q;
                  state_q <= S_NX0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CRC: begin
          crc_q <= {1'b0, crc_q[31:1]} ^ (crc_q[0] ? CrcPoly : 32'd0);
          bcnt_q <= 3'(bcnt_q + 1'b1);
          if (bcnt_q == 3'd7) state_q <= S_IDLE;
        end
        S_DFL, S_DFC, S_DSK: begin
          num_q <= q_fin;
          rem_q <= r_fin;
          step_q <= 5'(step_q + 1'b1);
          if (step_q == 5'd31) begin
            if (state_q == S_DFL) begin
              flen_q <= q_fin;
              if (q_fin == 32'd0) begin
                valid_q <= 1'b1;
                ev_q <= EV_HDR_BAD;
                state_q <= S_IDLE;
              end else begin
                num_q <= samp_q;
                den_q <= q_fin;
                rem_q <= '0;
                step_q <= '0;
                state_q <= S_DFC;
              end
            end else if (state_q == S_DFC) begin
              valid_q <= 1'b1;
              state_q <= S_IDLE;
              if (frames > 33'(MAX_FRAMES)) begin
                ev_q <= EV_HDR_BAD;
              end else begin
                ev_q <= EV_HDR_OK;
                cnt_frm_q <= frames[AW-1:0];
                sum_q <= mem_wd;
                phase_q <= PH_TABLE;
                pos_q <= '0;
                crc_q <= '1;
                wa_q <= '0;
                small_q <= 1'b0;
              end
            end else begin
              idx_q <= idx_min;
              next_q <= idx_min;
              raddr_q <= idx_min;
              mplier_q <= idx_min;
              mcand_q <= flen_q;
              acc_q <= '0;
              step_q <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc_q <= acc_fin;
          mcand_q <= {mcand_q[30:0], 1'b0};
          mplier_q <= mplier_q >> 1;
          step_q <= 5'(step_q + 1'b1);
          if (step_q == 5'(AW - 1)) begin
            valid_q <= 1'b1;
            ev_q <= EV_SEEK_DONE;
            ssamp_q <= acc_fin;
            off_q <= rdata_q;
            state_q <= S_IDLE;
          end
        end
        S_NX0: begin
          raddr_q <= AW'(next_q + 1'b1);
          state_q <= S_NX1;
        end
        S_NX1: begin
          fstart_q <= rdata_q;
          state_q <= S_NX2;
        end
        S_NX2: begin
          valid_q <= 1'b1;
          ev_q <= EV_FRM_READY;
          off_q <= fstart_q;
          idx_q <= next_q;
          fbytes_q <= rdata_q - fstart_q;
          next_q <= AW'(next_q + 1'b1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign event_code_o = ev_q;
  assign byte_offset_o = off_q;
  assign frame_index_o = 12'(idx_q);
  assign frame_bytes_o = fbytes_q;
  assign start_sample_o = ssamp_q;
  assign channel_count_o = chan_q;
  assign sample_bits_o = bits_q;
  assign sample_rate_o = rate_q;
  assign total_samples_o = samp_q;
  assign frame_samples_o = flen_q;
  assign total_frames_o = 12'(cnt_frm_q);

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !busy) else $error("result shown while busy");
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without a transaction");
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ev_q == EV_FRM_READY) |-> (fbytes_q >= MinFrame))
    else $error("frame shorter than the minimum");
  a_seek_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ev_q == EV_SEEK_DONE) |-> (idx_q <= cnt_frm_q))
    else $error("seek index beyond the frame count");

endmodule
